/* hw/rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies consequent, skipped in reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle, skipped in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// checked through reset as well
`define ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/ptpd_pkg.sv */
// ----------------------------------------------------------------------------
// ptpd_pkg
// widths, constants and the job record of the polyline distance block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptpd_pkg;

  localparam int COORD_WIDTH = 30;
  localparam int T_FRAC_BITS = 16;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W = 2 * COORD_WIDTH + 2;
  localparam int ACC_W = SQ_W + 1;
  localparam int DIST_W = SQ_W / 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int SR_W = ROOT_W + 4;
  localparam int CNT_W = 5;
  localparam int MUL_LAST = 8;
  localparam int PROJ_LAST = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t qx;
    coord_t qy;
    coord_t ax;
    coord_t ay;
    coord_t vx;
    coord_t vy;
    coord_t lx;
    coord_t ly;
    logic   seg_prev;
    logic   seg_land;
    logic   last;
  } job_t;

endpackage

/* hw/rtl/ptpd_if.sv */
// ----------------------------------------------------------------------------
// ptpd_item_if / ptpd_result_if
// valid-ready channels for vertex beats and distance results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptpd_item_if;
  logic valid;
  logic ready;
  logic signed [ptpd_pkg::COORD_WIDTH-1:0] query_x;
  logic signed [ptpd_pkg::COORD_WIDTH-1:0] query_y;
  logic signed [ptpd_pkg::COORD_WIDTH-1:0] vertex_x;
  logic signed [ptpd_pkg::COORD_WIDTH-1:0] vertex_y;
  logic signed [ptpd_pkg::COORD_WIDTH-1:0] landing_x;
  logic signed [ptpd_pkg::COORD_WIDTH-1:0] landing_y;
  logic leg_first;
  logic leg_final;
  logic query_final;
  modport source (output valid, query_x, query_y, vertex_x, vertex_y, landing_x, landing_y,
                  leg_first, leg_final, query_final, input ready);
  modport sink (input valid, query_x, query_y, vertex_x, vertex_y, landing_x, landing_y,
                leg_first, leg_final, query_final, output ready);
endinterface

interface ptpd_result_if;
  logic valid;
  logic ready;
  logic [ptpd_pkg::DIST_W-1:0] distance;
  logic no_segment;
  modport source (output valid, distance, no_segment, input ready);
  modport sink (input valid, distance, no_segment, output ready);
endinterface

/* hw/rtl/point_to_polyline_min_distance.sv */
// ----------------------------------------------------------------------------
// point_to_polyline_min_distance
// least distance from a query point to a multi-leg polyline
// ----------------------------------------------------------------------------
// Each vertex beat closes up to two segments. The back end runs one segment
// through a single shared multiplier, a radix-2 divider for the projection
// parameter and a projection pass; a segment whose projection falls on an
// end point skips the divider and the projection pass. The last beat of a
// query adds a square root before its result. A two-entry queue lets the
// front take beats while the back end works.
`timescale 1ns / 1ps

module point_to_polyline_min_distance (
  input  logic          clk,
  input  logic          rst,
  ptpd_item_if.sink     item,
  ptpd_result_if.source result
);

  ptpd_pkg::job_t push_job;
  ptpd_pkg::job_t pop_job;
  logic push_valid, push_ready, pop_valid, pop;

  ptpd_front u_front (
    .clk(clk), .rst(rst), .item(item),
    .push_job(push_job), .push_valid(push_valid), .push_ready(push_ready)
  );

  ptpd_queue u_queue (
    .clk(clk), .rst(rst),
    .push_job(push_job), .push_valid(push_valid), .push_ready(push_ready),
    .pop_job(pop_job), .pop_valid(pop_valid), .pop(pop)
  );

  ptpd_back u_back (
    .clk(clk), .rst(rst),
    .job(pop_job), .job_valid(pop_valid), .job_pop(pop), .result(result)
  );

endmodule

/* hw/rtl/ptpd_front.sv */
// ----------------------------------------------------------------------------
// ptpd_front
// accepts vertex beats, tracks the previous vertex and builds segment jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptpd_front (
  input  logic             clk,
  input  logic             rst,
  ptpd_item_if.sink        item,
  output ptpd_pkg::job_t   push_job,
  output logic             push_valid,
  input  logic             push_ready
);

  ptpd_pkg::coord_t prev_x;
  ptpd_pkg::coord_t prev_y;

  assign item.ready = push_ready;
  assign push_valid = item.valid;

  always_comb begin
    push_job.qx = item.query_x;
    push_job.qy = item.query_y;
    push_job.ax = prev_x;
    push_job.ay = prev_y;
    push_job.vx = item.vertex_x;
    push_job.vy = item.vertex_y;
    push_job.lx = item.landing_x;
    push_job.ly = item.landing_y;
    push_job.seg_prev = !item.leg_first;
    push_job.seg_land = item.leg_final;
    push_job.last = item.query_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (item.valid && item.ready) begin
      prev_x <= item.vertex_x;
      prev_y <= item.vertex_y;
    end
  end

endmodule

/* hw/rtl/ptpd_queue.sv */
// ----------------------------------------------------------------------------
// ptpd_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptpd_queue (
  input  logic           clk,
  input  logic           rst,
  input  ptpd_pkg::job_t push_job,
  input  logic           push_valid,
  output logic           push_ready,
  output ptpd_pkg::job_t pop_job,
  output logic           pop_valid,
  input  logic           pop
);

  ptpd_pkg::job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_job = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/ptpd_back.sv */
// ----------------------------------------------------------------------------
// ptpd_back
// segment distance sequencer with shared multiplier, divider and root steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptpd_back (
  input  logic           clk,
  input  logic           rst,
  input  ptpd_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_pop,
  ptpd_result_if.source  result
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_NEXT = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_PROJ = 7'b0010000,
    S_SQRT = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  localparam int DW = ptpd_pkg::DIFF_W;
  localparam int PW = ptpd_pkg::PROD_W;
  localparam int QW = ptpd_pkg::SQ_W;
  localparam int AW = ptpd_pkg::ACC_W;
  localparam int TW = ptpd_pkg::T_FRAC_BITS;
  localparam int RW = ptpd_pkg::ROOT_W;
  localparam int SW = ptpd_pkg::SR_W;
  localparam int CW = ptpd_pkg::CNT_W;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (TW - 1);

  state_t st;
  logic [CW-1:0] step;
  ptpd_pkg::job_t jb;
  logic need_prev;
  logic need_land;
  ptpd_pkg::coord_t ax, ay, bx, by;
  logic signed [PW-1:0] prod;
  logic [QW-1:0] len;
  logic signed [AW-1:0] dot;
  logic [QW-1:0] dw;
  logic [QW-1:0] acc;
  logic [AW-1:0] rem;
  logic [TW-1:0] t;
  logic signed [DW-1:0] offx, offy;
  logic [QW-1:0] best;
  logic any;
  logic [QW-1:0] sq_n;
  logic [SW-1:0] sq_rem;
  logic [RW-1:0] root;
  logic res_valid;
  logic [ptpd_pkg::DIST_W-1:0] res_dist;
  logic res_noseg;

  logic signed [DW-1:0] sx, sy, wx, wy, ex, ey, dx, dy, tt, opa, opb;
  logic signed [DW:0] dx_w, dy_w;
  logic signed [PW-1:0] rnd;
  logic [QW-1:0] de_sum, fold_d;
  logic use_start, use_end, fold_go;
  logic [AW-1:0] rem_sh, len_w;
  logic [SW-1:0] sq_sh, sq_trial;

  assign sx = DW'(bx) - DW'(ax);
  assign sy = DW'(by) - DW'(ay);
  assign wx = DW'(jb.qx) - DW'(ax);
  assign wy = DW'(jb.qy) - DW'(ay);
  assign ex = DW'(jb.qx) - DW'(bx);
  assign ey = DW'(jb.qy) - DW'(by);
  assign dx_w = (DW+1)'(jb.qx) - (DW+1)'(ax) - (DW+1)'(offx);
  assign dy_w = (DW+1)'(jb.qy) - (DW+1)'(ay) - (DW+1)'(offy);
  assign dx = dx_w[DW-1:0];
  assign dy = dy_w[DW-1:0];
  assign tt = {{(DW-TW){1'b0}}, t};
  assign rnd = prod + HALF;

  always_comb begin
    opa = '0;
    opb = '0;
    if (st == S_MUL) begin
      case (step)
        CW'(0): begin opa = sx; opb = sx; end
        CW'(1): begin opa = sy; opb = sy; end
        CW'(2): begin opa = wx; opb = sx; end
        CW'(3): begin opa = wy; opb = sy; end
        CW'(4): begin opa = wx; opb = wx; end
        CW'(5): begin opa = wy; opb = wy; end
        CW'(6): begin opa = ex; opb = ex; end
        CW'(7): begin opa = ey; opb = ey; end
        default: begin opa = '0; opb = '0; end
      endcase
    end else if (st == S_PROJ) begin
      case (step)
        CW'(0): begin opa = sx; opb = tt; end
        CW'(1): begin opa = sy; opb = tt; end
        CW'(2): begin opa = dx; opb = dx; end
        CW'(3): begin opa = dy; opb = dy; end
        default: begin opa = '0; opb = '0; end
      endcase
    end
  end

  assign de_sum = acc + prod[QW-1:0];
  assign len_w = {1'b0, len};
  assign use_start = (len == '0) || (dot <= 0);
  assign use_end = !use_start && ($signed(dot) >= $signed(len_w));

  always_comb begin
    if (st == S_PROJ) begin
      fold_d = acc + prod[QW-1:0];
    end else if (use_start) begin
      fold_d = dw;
    end else begin
      fold_d = de_sum;
    end
  end

  assign fold_go = (st == S_MUL && step == CW'(ptpd_pkg::MUL_LAST) && (use_start || use_end))
                || (st == S_PROJ && step == CW'(ptpd_pkg::PROJ_LAST));

  assign rem_sh = {rem[AW-2:0], 1'b0};
  assign sq_sh = {sq_rem[SW-3:0], sq_n[QW-1:QW-2]};
  assign sq_trial = {{(SW-RW-2){1'b0}}, root, 2'b01};

  assign job_pop = (st == S_IDLE) && job_valid;
  assign result.valid = res_valid;
  assign result.distance = res_dist;
  assign result.no_segment = res_noseg;

  always_ff @(posedge clk) begin
    prod <= PW'(opa * opb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      step <= '0;
      best <= '1;
      any <= 1'b0;
      res_valid <= 1'b0;
      need_prev <= 1'b0;
      need_land <= 1'b0;
    end else begin
      if (res_valid && result.ready) res_valid <= 1'b0;
      if (fold_go) begin
        if (fold_d < best) best <= fold_d;
        any <= 1'b1;
        st <= S_NEXT;
      end
      case (st)
        S_IDLE: begin
          if (job_valid) begin
            jb <= job;
            need_prev <= job.seg_prev;
            need_land <= job.seg_land;
            st <= S_NEXT;
          end
        end
        S_NEXT: begin
          step <= '0;
          if (need_prev) begin
            ax <= jb.ax;
            ay <= jb.ay;
            bx <= jb.vx;
            by <= jb.vy;
            need_prev <= 1'b0;
            st <= S_MUL;
          end else if (need_land) begin
            ax <= jb.vx;
            ay <= jb.vy;
            bx <= jb.lx;
            by <= jb.ly;
            need_land <= 1'b0;
            st <= S_MUL;
          end else if (jb.last) begin
            sq_n <= best;
            sq_rem <= '0;
            root <= '0;
            st <= S_SQRT;
          end else begin
            st <= S_IDLE;
          end
        end
        S_MUL: begin
          step <= step + CW'(1);
          case (step)
            CW'(1): len <= prod[QW-1:0];
            CW'(2): len <= len + prod[QW-1:0];
            CW'(3): dot <= AW'(prod);
            CW'(4): dot <= dot + AW'(prod);
            CW'(5): dw <= prod[QW-1:0];
            CW'(6): dw <= dw + prod[QW-1:0];
            CW'(7): acc <= prod[QW-1:0];
            CW'(ptpd_pkg::MUL_LAST): begin
              if (!use_start && !use_end) begin
                rem <= dot;
                t <= '0;
                step <= '0;
                st <= S_DIV;
              end
            end
            default: acc <= acc;
          endcase
        end
        S_DIV: begin
          step <= step + CW'(1);
          if (rem_sh >= len_w) begin
            rem <= rem_sh - len_w;
            t <= {t[TW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            t <= {t[TW-2:0], 1'b0};
          end
          if (step == CW'(TW - 1)) begin
            step <= '0;
            st <= S_PROJ;
          end
        end
        S_PROJ: begin
          step <= step + CW'(1);
          case (step)
            CW'(1): offx <= DW'(rnd >>> TW);
            CW'(2): offy <= DW'(rnd >>> TW);
            CW'(3): acc <= prod[QW-1:0];
            default: acc <= acc;
          endcase
        end
        S_SQRT: begin
          step <= step + CW'(1);
          sq_n <= {sq_n[QW-3:0], 2'b00};
          if (sq_sh >= sq_trial) begin
            sq_rem <= sq_sh - sq_trial;
            root <= {root[RW-2:0], 1'b1};
          end else begin
            sq_rem <= sq_sh;
            root <= {root[RW-2:0], 1'b0};
          end
          if (step == CW'(RW - 1)) st <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_dist <= any ? root : '1;
            res_noseg <= !any;
            best <= '1;
            any <= 1'b0;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/ptpd_checker.sv */
// ----------------------------------------------------------------------------
// ptpd_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptpd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        valid,
  input logic                        ready,
  input logic [ptpd_pkg::DIST_W-1:0] distance,
  input logic                        no_segment
);

  `ASSERT_SAME(a_empty_sat, clk, rst, valid && no_segment, distance == '1)
  `ASSERT_SAME(a_real_not_sat, clk, rst, valid && !no_segment, distance != '1)
  `ASSERT_NEXT(a_hold_valid, clk, rst, valid && !ready, valid)
  `ASSERT_ALWAYS_NEXT(a_reset_quiet, clk, rst, !valid)

endmodule

bind point_to_polyline_min_distance ptpd_checker u_ptpd_checker (
  .clk(clk), .rst(rst), .valid(result.valid), .ready(result.ready),
  .distance(result.distance), .no_segment(result.no_segment)
);

/* verif/point_to_polyline_min_distance_tb.sv */
// ----------------------------------------------------------------------------
// point_to_polyline_min_distance_tb
// Streams vertex beats into the polyline distance block and checks each
// result against an in-bench model of the segment distance fold and the
// integer square root. Both channels idle at random, and the result side
// holds off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_to_polyline_min_distance_tb;

  localparam int LIMIT = 1000000;
  localparam int RANDOM_BEATS = 1250;
  localparam longint unsigned BEST_INIT = (64'd1 << 62) - 1;
  localparam logic [ptpd_pkg::DIST_W-1:0] DIST_SAT = '1;

  typedef struct {
    logic [ptpd_pkg::DIST_W-1:0] distance;
    logic                        no_segment;
  } dist_result_t;

  class distance_scoreboard;
    longint          last_x, last_y;
    longint unsigned min_sq;
    bit              seen_segment;
    dist_result_t    pending[$];
    int              errors;

    function new();
      last_x = 0;
      last_y = 0;
      min_sq = BEST_INIT;
      seen_segment = 0;
      errors = 0;
    endfunction

    function longint unsigned norm_sq(longint dx, longint dy);
      return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    function longint unsigned segment_sq(longint ax, longint ay, longint bx,
                                         longint by, longint qx, longint qy);
      longint sx, sy, len, wx, wy, dot, px, py, half;
      longint unsigned rem, t;
      sx = bx - ax;
      sy = by - ay;
      len = sx * sx + sy * sy;
      wx = qx - ax;
      wy = qy - ay;
      if (len == 0) return norm_sq(wx, wy);
      dot = wx * sx + wy * sy;
      if (dot <= 0) return norm_sq(wx, wy);
      if (dot >= len) return norm_sq(qx - bx, qy - by);
      rem = dot;
      t = 0;
      for (int i = 0; i < ptpd_pkg::T_FRAC_BITS; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= longint'(len)) begin
          rem = rem - len;
          t = t | 1;
        end
      end
      half = longint'(1) << (ptpd_pkg::T_FRAC_BITS - 1);
      px = ax + ((sx * longint'(t) + half) >>> ptpd_pkg::T_FRAC_BITS);
      py = ay + ((sy * longint'(t) + half) >>> ptpd_pkg::T_FRAC_BITS);
      return norm_sq(qx - px, qy - py);
    endfunction

    function longint unsigned floor_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void fold(longint unsigned d);
      if (d < min_sq) min_sq = d;
      seen_segment = 1;
    endfunction

    function void note_beat(ptpd_pkg::coord_t qx, ptpd_pkg::coord_t qy,
                            ptpd_pkg::coord_t vx, ptpd_pkg::coord_t vy,
                            ptpd_pkg::coord_t lx, ptpd_pkg::coord_t ly,
                            logic first, logic leg_end, logic query_end);
      dist_result_t r;
      if (!first) fold(segment_sq(last_x, last_y, vx, vy, qx, qy));
      if (leg_end) fold(segment_sq(vx, vy, lx, ly, qx, qy));
      last_x = vx;
      last_y = vy;
      if (query_end) begin
        if (seen_segment) begin
          r.distance = ptpd_pkg::DIST_W'(floor_root(min_sq));
          r.no_segment = 0;
        end else begin
          r.distance = DIST_SAT;
          r.no_segment = 1;
        end
        pending = {pending, r};
        min_sq = BEST_INIT;
        seen_segment = 0;
      end
    endfunction

    function void check_result(logic [ptpd_pkg::DIST_W-1:0] distance, logic no_segment);
      dist_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result distance=%0d no_segment=%0d", distance, no_segment);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (distance !== e.distance) begin
        $error("distance: expected %0d, got %0d", e.distance, distance);
        errors++;
      end
      if (no_segment !== e.no_segment) begin
        $error("no_segment: expected %0d, got %0d", e.no_segment, no_segment);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  int   cycles = 0;
  int   beats_in = 0;
  bit   calm = 0;

  ptpd_item_if   item();
  ptpd_result_if result();

  point_to_polyline_min_distance uut (
    .clk(clk),
    .rst(rst),
    .item(item.sink),
    .result(result.source)
  );

  distance_scoreboard sb = new();

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && item.valid && item.ready) begin
      sb.note_beat(item.query_x, item.query_y, item.vertex_x, item.vertex_y,
                   item.landing_x, item.landing_y, item.leg_first, item.leg_final,
                   item.query_final);
      beats_in++;
    end
    if (!rst && result.valid && result.ready)
      sb.check_result(result.distance, result.no_segment);
  end

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic ptpd_pkg::coord_t rand_coord(int span);
    case (span)
      0: return ptpd_pkg::coord_t'($signed($urandom_range(0, 8191)) - 4096);
      1: return ptpd_pkg::coord_t'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return ptpd_pkg::coord_t'($urandom);
    endcase
  endfunction

  task automatic send_beat(ptpd_pkg::coord_t qx, ptpd_pkg::coord_t qy,
                           ptpd_pkg::coord_t vx, ptpd_pkg::coord_t vy,
                           ptpd_pkg::coord_t lx, ptpd_pkg::coord_t ly,
                           logic first, logic leg_end, logic query_end);
    int g;
    item.query_x <= qx;
    item.query_y <= qy;
    item.vertex_x <= vx;
    item.vertex_y <= vy;
    item.landing_x <= lx;
    item.landing_y <= ly;
    item.leg_first <= first;
    item.leg_final <= leg_end;
    item.query_final <= query_end;
    item.valid <= 1;
    do @(posedge clk); while (!item.ready);
    g = idle_gap();
    if (g > 0) begin
      item.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_query();
    ptpd_pkg::coord_t qx, qy, lx, ly;
    int span, legs, verts;
    span = $urandom_range(0, 2);
    qx = rand_coord(span);
    qy = rand_coord(span);
    lx = rand_coord(span);
    ly = rand_coord(span);
    legs = $urandom_range(1, 3);
    for (int l = 0; l < legs; l++) begin
      verts = $urandom_range(1, 4);
      for (int v = 0; v < verts; v++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2),
                    rand_coord(2), rand_coord(2), 1'($urandom), 1'($urandom),
                    1'($urandom));
        else
          send_beat(qx, qy, rand_coord(span), rand_coord(span), lx, ly, v == 0,
                    v == verts - 1, (l == legs - 1) && (v == verts - 1));
      end
    end
  endtask

  initial begin
    ptpd_pkg::coord_t mx, mn;
    mx = {1'b0, {(ptpd_pkg::COORD_WIDTH-1){1'b1}}};
    mn = {1'b1, {(ptpd_pkg::COORD_WIDTH-1){1'b0}}};
    rst <= 1;
    item.valid <= 0;
    item.query_x <= 0;
    item.query_y <= 0;
    item.vertex_x <= 0;
    item.vertex_y <= 0;
    item.landing_x <= 0;
    item.landing_y <= 0;
    item.leg_first <= 0;
    item.leg_final <= 0;
    item.query_final <= 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // leg start missing right after reset, segment from origin
    send_beat(100, 50, 200, 0, 0, 0, 0, 0, 1);
    // empty query
    send_beat(5, 5, 7, 7, 9, 9, 1, 0, 1);
    // zero-length segment, then zero-length landing segment
    send_beat(1000, -1000, 300, 300, 0, 0, 1, 0, 0);
    send_beat(1000, -1000, 300, 300, 300, 300, 0, 1, 1);
    // projection before start, past end, and interior
    send_beat(-500, 0, 0, 0, 0, 0, 1, 0, 0);
    send_beat(-500, 0, 1000, 0, 0, 0, 0, 0, 1);
    send_beat(5000, 3, 0, 0, 0, 0, 1, 0, 0);
    send_beat(5000, 3, 1000, 0, 0, 0, 0, 0, 1);
    send_beat(333, 777, 0, 0, 0, 0, 1, 0, 0);
    send_beat(333, 777, 1001, 3, 17, 2000, 0, 1, 1);
    // extremes of the coordinate range
    send_beat(mx, mn, mn, mx, mx, mx, 1, 0, 0);
    send_beat(mx, mn, mx, mn, mn, mn, 0, 1, 1);
    send_beat(mn, mn, mx, mx, mn, mx, 1, 1, 1);
    send_beat(0, 0, mn, mn, mx, mx, 1, 1, 0);
    send_beat(mx, 0, -1, 1, mn, 0, 0, 1, 1);
    // two queries without a leg start, stored vertex carries over
    send_beat(-1, -1, 12345, -54321, 0, 0, 0, 0, 1);
    send_beat(77, 88, -12345, 54321, 0, 0, 0, 1, 1);

    while (beats_in < RANDOM_BEATS) begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      send_query();
    end
    item.valid <= 0;
    @(posedge clk);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int g;
    bit stalled;
    stalled = 0;
    result.ready <= 0;
    @(negedge rst);
    forever begin
      if (!stalled && beats_in > 400) begin
        stalled = 1;
        result.ready <= 0;
        repeat (1500) @(posedge clk);
      end
      g = idle_gap();
      if (g > 0) begin
        result.ready <= 0;
        repeat (g) @(posedge clk);
      end
      result.ready <= 1;
      @(posedge clk);
    end
  end

endmodule
